@@ rtl/core/gauss_elimination_determinant_defines.svh @@
// Assertion helpers shared by the RTL.
`ifndef GAUSS_ELIMINATION_DETERMINANT_DEFINES_SVH
`define GAUSS_ELIMINATION_DETERMINANT_DEFINES_SVH

// Check a property on every edge, outside reset.
`define GED_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies a second one in the next cycle.
`define GED_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

@@ rtl/core/ged_pkg.sv @@
package ged_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned STAT_W = 2;

	typedef logic [STAT_W-1:0] status_t;
	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_NOT_SQ   = 2'd1;
	localparam status_t ST_ZERO_PIV = 2'd2;
	localparam status_t ST_OVF      = 2'd3;

	localparam logic CFG_ROWS = 1'b0;
	localparam logic CFG_COLS = 1'b1;

	typedef enum logic [3:0] {
		S_LOAD,
		S_PIV_RD,
		S_PIV_CHK,
		S_ROW_RD,
		S_DIV,
		S_K_RD,
		S_K_MUL,
		S_K_WR,
		S_DET_RD,
		S_DET_MUL,
		S_DET_ACC,
		S_DONE
	} ged_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_RD_PIV,
		OP_LATCH_PIV,
		OP_RD_AJI,
		OP_DIV_START,
		OP_RD_AIK,
		OP_RD_AJK,
		OP_MUL,
		OP_WR_AJK,
		OP_DET_INIT,
		OP_DET_MUL,
		OP_DET_ACC
	} ged_op_t;

	// sequencer -> datapath
	typedef struct packed {
		ged_op_t    op;
		logic [4:0] i;
		logic [4:0] j;
		logic [4:0] k;
	} ged_cmd_t;

	// datapath -> sequencer
	typedef struct packed {
		logic piv_zero;
		logic div_done;
		logic ovf;
	} ged_stat_t;

	function automatic logic [WORD_W-1:0] sat32(input logic signed [95:0] v);
		logic signed [95:0] mx;
		logic signed [95:0] mn;
		mx = 96'sh7FFF_FFFF;
		mn = -96'sh8000_0000;
		if (v > mx) return 32'h7FFF_FFFF;
		if (v < mn) return 32'h8000_0000;
		return v[WORD_W-1:0];
	endfunction

	function automatic logic is_sat(input logic signed [95:0] v);
		return (v > 96'sh7FFF_FFFF) || (v < -96'sh8000_0000);
	endfunction

endpackage

@@ rtl/core/ged_ram.sv @@
module ged_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

@@ rtl/core/ged_div.sv @@
// Restoring signed divide: quotient = (num << FRAC) / den, truncated toward zero.
module ged_div #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] num,
	input  logic signed [31:0] den,
	output logic               done,
	output logic signed [63:0] quot
);
	localparam int unsigned NW = 32 + FRAC_BITS;
	localparam int unsigned CW = $clog2(NW + 1);

	logic [NW-1:0] n_q;
	logic [NW-1:0] q_q;
	logic [32:0]   r_q;
	logic [31:0]   d_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic [33:0]   trial;
	logic [32:0]   rsh;
	logic [NW-1:0] q_mag;

	always_comb begin
		rsh   = {r_q[31:0], n_q[NW-1]};
		trial = {1'b0, rsh} - {2'b0, d_q};
		q_mag = q_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= {(num[31] ? 32'(-num) : 32'(num)), {FRAC_BITS{1'b0}}};
			d_q   <= den[31] ? 32'(-den) : 32'(den);
			neg_q <= num[31] ^ den[31];
			r_q   <= '0;
			q_q   <= '0;
		end else if (run_q) begin
			n_q <= {n_q[NW-2:0], 1'b0};
			if (!trial[33]) begin
				r_q <= trial[32:0];
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				r_q <= rsh;
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end
	end

	assign quot = neg_q ? -$signed(64'(q_mag)) : $signed(64'(q_mag));
endmodule

@@ rtl/core/ged_datapath.sv @@
module ged_datapath #(
	parameter int unsigned MAX_DIM   = 8,
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ged_pkg::ged_cmd_t   cmd,
	input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0] load_addr,
	input  logic [4:0]          dim,
	input  logic signed [31:0]  element_value,
	output ged_pkg::ged_stat_t  stat,
	output logic [31:0]         det_q
);
	import ged_pkg::*;
	localparam int unsigned AW = $clog2(MAX_DIM*MAX_DIM);
	localparam logic signed [95:0] RND_ADD = (96'sd1 <<< FRAC_BITS) - 96'sd1;

	logic [AW-1:0]      raddr;
	logic [AW-1:0]      waddr;
	logic [31:0]        wdata;
	logic               we;
	logic [31:0]        rdata;
	logic signed [31:0] piv_q;
	logic signed [31:0] ratio_q;
	logic signed [31:0] aik_q;
	logic signed [63:0] prod_q;
	logic               ovf_q;
	logic               div_done;
	logic signed [63:0] quot;
	logic signed [95:0] diff;
	logic signed [95:0] dq;
	logic               div_go;

	function automatic logic [AW-1:0] addr(input logic [4:0] r, input logic [4:0] c,
			input logic [4:0] n);
		logic [9:0] a;
		a = 10'(r) * 10'(n) + 10'(c);
		return a[AW-1:0];
	endfunction

	always_comb begin
		raddr  = '0;
		we     = 1'b0;
		waddr  = load_addr;
		wdata  = element_value;
		div_go = (cmd.op == OP_DIV_START);
		unique case (cmd.op)
			OP_LOAD:    we = 1'b1;
			OP_RD_PIV:  raddr = addr(cmd.i, cmd.i, dim);
			OP_RD_AJI:  raddr = addr(cmd.j, cmd.i, dim);
			OP_RD_AIK:  raddr = addr(cmd.i, cmd.k, dim);
			OP_RD_AJK:  raddr = addr(cmd.j, cmd.k, dim);
			OP_WR_AJK: begin
				we    = 1'b1;
				waddr = addr(cmd.j, cmd.k, dim);
				wdata = sat32(diff);
			end
			default: ;
		endcase
	end

	// truncate-toward-zero shift of a product
	always_comb begin
		dq   = ($signed(96'(prod_q)) + (prod_q[63] ? RND_ADD : 96'sd0)) >>> FRAC_BITS;
		diff = $signed(96'($signed(rdata))) - dq;
	end

	ged_ram #(.WIDTH(32), .DEPTH(MAX_DIM*MAX_DIM)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	ged_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go), .num($signed(rdata)), .den(piv_q),
		.done(div_done), .quot(quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q <= 1'b0;
		end else begin
			unique case (cmd.op)
				OP_LOAD:     ovf_q <= 1'b0;
				OP_WR_AJK:   if (is_sat(diff)) ovf_q <= 1'b1;
				OP_DET_ACC:  if (is_sat(dq)) ovf_q <= 1'b1;
				default:     if (div_done && is_sat(96'(quot))) ovf_q <= 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LATCH_PIV) piv_q <= rdata;
		if (div_done) ratio_q <= sat32(96'(quot));
		if (cmd.op == OP_MUL) aik_q <= rdata;
		if (cmd.op == OP_RD_AJK) prod_q <= ratio_q * aik_q;
		if (cmd.op == OP_DET_INIT) det_q <= 32'(64'sd1 <<< FRAC_BITS);
		if (cmd.op == OP_DET_MUL) prod_q <= $signed(det_q) * $signed(rdata);
		if (cmd.op == OP_DET_ACC) det_q <= sat32(dq);
	end

	assign stat.piv_zero = (rdata == '0);
	assign stat.div_done = div_done;
	assign stat.ovf      = ovf_q;
endmodule

@@ rtl/core/ged_ctrl.sv @@
module ged_ctrl #(
	parameter int unsigned MAX_DIM = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               cfg_clr,
	input  logic [4:0]         rows,
	input  logic [4:0]         cols,
	input  ged_pkg::ged_stat_t stat,
	output ged_pkg::ged_cmd_t  cmd,
	output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] load_addr,
	output logic               busy,
	output logic               done,
	output ged_pkg::status_t   res_status,
	output logic               res_zero
);
	import ged_pkg::*;
	localparam int unsigned AW = $clog2(MAX_DIM*MAX_DIM);

	ged_state_t st_q, st_d;
	logic [AW:0] cnt_q, cnt_d;
	logic [4:0]  i_q, j_q, k_q, i_d, j_d, k_d;
	logic [9:0]  total;
	logic        fin_d;
	status_t     rs_d;
	logic        rz_d;

	assign total = 10'(rows) * 10'(cols);
	assign load_addr = cnt_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_LOAD; cnt_q <= '0; i_q <= '0; j_q <= '0; k_q <= '0;
			done <= 1'b0; res_status <= ST_OK; res_zero <= 1'b0;
		end else begin
			st_q <= st_d; cnt_q <= cnt_d; i_q <= i_d; j_q <= j_d; k_q <= k_d;
			done <= fin_d; res_status <= rs_d; res_zero <= rz_d;
		end
	end

	always_comb begin
		st_d = st_q; cnt_d = cnt_q; i_d = i_q; j_d = j_q; k_d = k_q;
		fin_d = 1'b0; rs_d = res_status; rz_d = res_zero;
		cmd = '{op: OP_NONE, i: i_q, j: j_q, k: k_q};
		busy = (st_q != S_LOAD);
		unique case (st_q)
			S_LOAD: begin
				if (cfg_clr) cnt_d = '0;
				else if (start) begin
					cmd.op = OP_LOAD;
					if (10'(cnt_q) + 10'd1 >= total) begin
						cnt_d = '0;
						if (rows != cols) begin
							fin_d = 1'b1; rs_d = ST_NOT_SQ; rz_d = 1'b1;
						end else begin
							i_d = '0; st_d = S_PIV_RD;
						end
					end else cnt_d = cnt_q + 1'b1;
				end
			end
			S_PIV_RD: begin
				cmd.op = OP_RD_PIV;
				if (i_q == rows) begin
					i_d = '0; st_d = S_DET_RD; cmd.op = OP_DET_INIT;
				end else st_d = S_PIV_CHK;
			end
			S_PIV_CHK: begin
				cmd.op = OP_LATCH_PIV;
				if (stat.piv_zero) begin
					fin_d = 1'b1; rs_d = ST_ZERO_PIV; rz_d = 1'b1; st_d = S_LOAD;
				end else begin
					j_d = i_q + 1'b1; st_d = S_ROW_RD;
				end
			end
			S_ROW_RD: begin
				if (j_q >= rows) begin
					i_d = i_q + 1'b1; st_d = S_PIV_RD;
				end else begin
					cmd.op = OP_RD_AJI; st_d = S_DIV;
				end
			end
			S_DIV: begin
				// first cycle kicks the divider with a[j][i] on the read port
				if (k_q != 5'd30) begin
					cmd.op = OP_DIV_START; k_d = 5'd30;
				end else if (stat.div_done) begin
					k_d = '0; st_d = S_K_RD;
				end
			end
			S_K_RD: begin
				if (k_q == rows) begin
					j_d = j_q + 1'b1; st_d = S_ROW_RD;
				end else begin
					cmd.op = OP_RD_AIK; st_d = S_K_MUL;
				end
			end
			S_K_MUL: begin
				cmd.op = OP_MUL; st_d = S_K_WR;
			end
			S_K_WR: begin
				cmd.op = OP_RD_AJK; st_d = S_DONE;
			end
			S_DONE: begin
				// a[j][k] now on read port; product registered
				cmd.op = OP_WR_AJK; k_d = k_q + 1'b1; st_d = S_K_RD;
			end
			S_DET_RD: begin
				if (i_q == rows) begin
					fin_d = 1'b1; rz_d = 1'b0;
					rs_d = stat.ovf ? ST_OVF : ST_OK; st_d = S_LOAD;
				end else begin
					cmd.op = OP_RD_PIV; st_d = S_DET_MUL;
				end
			end
			S_DET_MUL: begin
				cmd.op = OP_DET_MUL; st_d = S_DET_ACC;
			end
			S_DET_ACC: begin
				cmd.op = OP_DET_ACC; i_d = i_q + 1'b1; st_d = S_DET_RD;
			end
			default: st_d = S_LOAD;
		endcase
	end
endmodule

@@ rtl/core/gauss_elimination_determinant.sv @@
// Channel   | Signals                          | Handshake
// ----------+----------------------------------+--------------------------
// element   | start, element_value             | taken when start && !busy && !cfg_we
// result    | done, determinant, status        | one-cycle strobe, no stall
// config    | cfg_we, cfg_index, cfg_data      | written when cfg_we
//
// Loading accepts one element per cycle. After the last element of a square
// matrix the sequencer runs elimination through one shared RAM read port and
// one serial divider (pivot check, divide per row ratio, then read, multiply
// and write back per updated element), then multiplies in each diagonal term.
// Reset clears control state only; the matrix RAM holds stale data until
// loaded. busy holds the element port off meanwhile; done strobes one cycle.
`include "gauss_elimination_determinant_defines.svh"
module gauss_elimination_determinant #(
	parameter int unsigned MAX_DIM   = 8,
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] element_value,
	output logic               done,
	output logic signed [31:0] determinant,
	output logic [1:0]         status,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [3:0]         cfg_data
);
	import ged_pkg::*;
	localparam int unsigned AW = $clog2(MAX_DIM*MAX_DIM);

	logic [3:0] rows_q;
	logic [3:0] cols_q;
	logic [4:0] rows_eff;
	logic [4:0] cols_eff;
	ged_cmd_t   cmd;
	ged_stat_t  stat;
	logic [AW-1:0] load_addr;
	logic [31:0]   det_q;
	status_t       res_status;
	logic          res_zero;

	// clamp dimensions: zero counts as one, large counts as MAX_DIM
	function automatic logic [4:0] clamp(input logic [3:0] v);
		if (v == 4'd0) return 5'd1;
		if (5'(v) > 5'(MAX_DIM)) return 5'(MAX_DIM);
		return 5'(v);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 4'd1;
			cols_q <= 4'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROWS: rows_q <= cfg_data;
				CFG_COLS: cols_q <= cfg_data;
			endcase
		end
	end

	assign rows_eff = clamp(rows_q);
	assign cols_eff = clamp(cols_q);

	ged_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .cfg_clr(cfg_we),
		.rows(rows_eff), .cols(cols_eff), .stat(stat), .cmd(cmd),
		.load_addr(load_addr), .busy(busy), .done(done),
		.res_status(res_status), .res_zero(res_zero)
	);

	ged_datapath #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .load_addr(load_addr),
		.dim(rows_eff), .element_value(element_value), .stat(stat), .det_q(det_q)
	);

	// zero the value on error results
	assign determinant = res_zero ? '0 : $signed(det_q);
	assign status      = res_status;

	`GED_ASSERT(a_err_zero, !done || status == ST_OK || status == ST_OVF || determinant == '0, "error result carries nonzero determinant")
	`GED_ASSERT_NEXT(a_done_pulse, done, !done, "done held longer than one beat")
	`GED_ASSERT(a_busy_no_load, !busy || cmd.op != OP_LOAD, "load while busy")
endmodule
